FILE: rtl/core/cctbb_pkg.sv
// ----------------------------------------------------------------------------
// cctbb_pkg
// Shared codes, field widths and the control word for the chain code tracer.
// ----------------------------------------------------------------------------
package cctbb_pkg;

  localparam int FIELD_W = 16;
  localparam int PAD_W   = 17;
  localparam int FUNC_W  = 2;
  localparam int DIR_W   = 3;

  // Function codes of an input word.
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  // Operations handed from the front end to the back end.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic              hit;
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } cctbb_ctl_t;

endpackage

FILE: rtl/core/cctbb_if.sv
// ----------------------------------------------------------------------------
// cctbb_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface cctbb_in_if;
  import cctbb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [FIELD_W-1:0] start_x;
  logic signed [FIELD_W-1:0] start_y;
  logic                      chain_type;
  logic [DIR_W-1:0]          direction;

  modport source (output valid, func, start_x, start_y, chain_type, direction,
                  input ready);
  modport sink (input valid, func, start_x, start_y, chain_type, direction,
                output ready);
endinterface

interface cctbb_out_if;
  import cctbb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] far_x;
  logic signed [FIELD_W-1:0] far_y;
  logic [PAD_W-1:0]          padded_width;
  logic [PAD_W-1:0]          padded_height;
  logic                      clipped;

  modport source (output valid, kind, pos_x, pos_y, far_x, far_y, padded_width,
                  padded_height, clipped, input ready);
  modport sink (input valid, kind, pos_x, pos_y, far_x, far_y, padded_width,
                padded_height, clipped, output ready);
endinterface

FILE: rtl/core/cctbb_front.sv
// ----------------------------------------------------------------------------
// cctbb_front
// Accepts input words, clamps start points and decodes move directions.
// ----------------------------------------------------------------------------
module cctbb_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cctbb_in_if.sink                      in_ch,
  input  logic                          q_ready,
  output logic                          push,
  output cctbb_pkg::cctbb_ctl_t         push_ctl,
  output logic signed [COORD_WIDTH-1:0] push_x,
  output logic signed [COORD_WIDTH-1:0] push_y
);
  import cctbb_pkg::*;

  localparam int EW = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam logic signed [EW-1:0] CMAX_E =
    EW'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
  localparam logic signed [EW-1:0] CMIN_E = ~CMAX_E;

  logic                 mode_r;
  logic                 mode_nxt;
  logic                 accept;
  logic signed [EW-1:0] sx_ext;
  logic signed [EW-1:0] sy_ext;
  logic signed [EW-1:0] sx_sat;
  logic signed [EW-1:0] sy_sat;
  logic                 hit_x;
  logic                 hit_y;
  logic signed [1:0]    dx;
  logic signed [1:0]    dy;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  // Start point: sign extend, then clamp each axis to the coordinate range.
  assign sx_ext = EW'(in_ch.start_x);
  assign sy_ext = EW'(in_ch.start_y);

  always_comb begin
    hit_x  = 1'b0;
    hit_y  = 1'b0;
    sx_sat = sx_ext;
    sy_sat = sy_ext;
    if (sx_ext > CMAX_E) begin
      sx_sat = CMAX_E;
      hit_x  = 1'b1;
    end else if (sx_ext < CMIN_E) begin
      sx_sat = CMIN_E;
      hit_x  = 1'b1;
    end
    if (sy_ext > CMAX_E) begin
      sy_sat = CMAX_E;
      hit_y  = 1'b1;
    end else if (sy_ext < CMIN_E) begin
      sy_sat = CMIN_E;
      hit_y  = 1'b1;
    end
  end

  // Direction decode under the mode of the chain in progress.
  always_comb begin
    dx = 2'sd0;
    dy = 2'sd0;
    if (mode_r) begin
      case (in_ch.direction)
        3'd0:    dx = 2'sd1;
        3'd1:    dy = 2'sd1;
        3'd2:    dx = -2'sd1;
        3'd3:    dy = -2'sd1;
        default: begin
          dx = 2'sd0;
          dy = 2'sd0;
        end
      endcase
    end else begin
      case (in_ch.direction)
        3'd0: begin dx = 2'sd1;  dy = 2'sd0;  end
        3'd1: begin dx = 2'sd1;  dy = 2'sd1;  end
        3'd2: begin dx = 2'sd0;  dy = 2'sd1;  end
        3'd3: begin dx = -2'sd1; dy = 2'sd1;  end
        3'd4: begin dx = -2'sd1; dy = 2'sd0;  end
        3'd5: begin dx = -2'sd1; dy = -2'sd1; end
        3'd6: begin dx = 2'sd0;  dy = -2'sd1; end
        default: begin dx = 2'sd1; dy = -2'sd1; end
      endcase
    end
  end

  always_comb begin
    push          = 1'b0;
    push_ctl.op   = OP_LOAD;
    push_ctl.hit  = 1'b0;
    push_ctl.dx   = dx;
    push_ctl.dy   = dy;
    push_x        = sx_sat[COORD_WIDTH-1:0];
    push_y        = sy_sat[COORD_WIDTH-1:0];
    mode_nxt      = mode_r;
    case (in_ch.func)
      FUNC_START: begin
        push         = accept;
        push_ctl.op  = OP_LOAD;
        push_ctl.hit = hit_x || hit_y;
        if (accept) begin
          mode_nxt = in_ch.chain_type;
        end
      end
      FUNC_STEP: begin
        push        = accept;
        push_ctl.op = OP_MOVE;
      end
      FUNC_FINISH: begin
        push        = accept;
        push_ctl.op = OP_REPORT;
      end
      default: begin
        // The unused code is taken and dropped.
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule

FILE: rtl/core/cctbb_queue.sv
// ----------------------------------------------------------------------------
// cctbb_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cctbb_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0]      mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [AW:0]        count_r;
  logic [AW-1:0]      wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_nxt;
  logic [AW:0]        count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != (AW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/cctbb_back.sv
// ----------------------------------------------------------------------------
// cctbb_back
// Applies moves with saturation, tracks the bounding box, registers results.
// ----------------------------------------------------------------------------
module cctbb_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cctbb_pkg::cctbb_ctl_t         q_ctl,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  output logic                          pop,
  cctbb_out_if.source                   out_ch
);
  import cctbb_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int SW = CW + 2;
  localparam logic signed [CW-1:0] CMAX = CW'((65'sd1 <<< (CW - 1)) - 65'sd1);
  localparam logic signed [CW-1:0] CMIN = ~CMAX;

  logic signed [CW-1:0] cur_x_r, cur_y_r;
  logic signed [CW-1:0] least_x_r, least_y_r, most_x_r, most_y_r;
  logic                 seen_r;
  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [CW-1:0] least_x_nxt, least_y_nxt, most_x_nxt, most_y_nxt;
  logic                 seen_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      kind_r, kind_nxt;
  logic signed [FIELD_W-1:0] pos_x_r, pos_y_r, far_x_r, far_y_r;
  logic signed [FIELD_W-1:0] pos_x_nxt, pos_y_nxt, far_x_nxt, far_y_nxt;
  logic [PAD_W-1:0]          pad_w_r, pad_h_r, pad_w_nxt, pad_h_nxt;
  logic                      clip_r, clip_nxt;

  logic [CW:0]          sum_x, sum_y;
  logic                 ovf_x, ovf_y;
  logic signed [CW-1:0] sat_x, sat_y;
  logic signed [CW-1:0] new_x, new_y;
  logic                 new_hit;
  logic [CW:0]          span_x, span_y;
  logic [SW-1:0]        size_x, size_y;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  // One step with saturation per axis.
  assign sum_x = {cur_x_r[CW-1], cur_x_r} + (CW+1)'(q_ctl.dx);
  assign sum_y = {cur_y_r[CW-1], cur_y_r} + (CW+1)'(q_ctl.dy);
  assign ovf_x = sum_x[CW] ^ sum_x[CW-1];
  assign ovf_y = sum_y[CW] ^ sum_y[CW-1];
  assign sat_x = ovf_x ? (sum_x[CW] ? CMIN : CMAX) : sum_x[CW-1:0];
  assign sat_y = ovf_y ? (sum_y[CW] ? CMIN : CMAX) : sum_y[CW-1:0];

  assign new_x   = (q_ctl.op == OP_LOAD) ? q_x : sat_x;
  assign new_y   = (q_ctl.op == OP_LOAD) ? q_y : sat_y;
  assign new_hit = (q_ctl.op == OP_LOAD) ? q_ctl.hit : (ovf_x || ovf_y);

  // Span plus one, rounded up to even: (span + 2) with the low bit cleared.
  assign span_x = {most_x_r[CW-1], most_x_r} - {least_x_r[CW-1], least_x_r};
  assign span_y = {most_y_r[CW-1], most_y_r} - {least_y_r[CW-1], least_y_r};
  assign size_x = (SW'(span_x) + SW'(2)) & ~SW'(1);
  assign size_y = (SW'(span_y) + SW'(2)) & ~SW'(1);

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    least_x_nxt = least_x_r;
    least_y_nxt = least_y_r;
    most_x_nxt  = most_x_r;
    most_y_nxt  = most_y_r;
    seen_nxt    = seen_r;
    kind_nxt    = kind_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    far_x_nxt   = far_x_r;
    far_y_nxt   = far_y_r;
    pad_w_nxt   = pad_w_r;
    pad_h_nxt   = pad_h_r;
    clip_nxt    = clip_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (q_ctl.op == OP_REPORT) begin
        kind_nxt  = KIND_BOX;
        clip_nxt  = 1'b0;
        pos_x_nxt = seen_r ? FIELD_W'(least_x_r) : '0;
        pos_y_nxt = seen_r ? FIELD_W'(least_y_r) : '0;
        far_x_nxt = seen_r ? FIELD_W'(most_x_r) : '0;
        far_y_nxt = seen_r ? FIELD_W'(most_y_r) : '0;
        pad_w_nxt = seen_r ? PAD_W'(size_x) : '0;
        pad_h_nxt = seen_r ? PAD_W'(size_y) : '0;
        least_x_nxt = CMAX;
        least_y_nxt = CMAX;
        most_x_nxt  = CMIN;
        most_y_nxt  = CMIN;
        seen_nxt    = 1'b0;
      end else begin
        cur_x_nxt = new_x;
        cur_y_nxt = new_y;
        if (new_x < least_x_r) least_x_nxt = new_x;
        if (new_x > most_x_r)  most_x_nxt  = new_x;
        if (new_y < least_y_r) least_y_nxt = new_y;
        if (new_y > most_y_r)  most_y_nxt  = new_y;
        seen_nxt  = 1'b1;
        kind_nxt  = KIND_PIXEL;
        clip_nxt  = new_hit;
        pos_x_nxt = FIELD_W'(new_x);
        pos_y_nxt = FIELD_W'(new_y);
        far_x_nxt = '0;
        far_y_nxt = '0;
        pad_w_nxt = '0;
        pad_h_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      least_x_r   <= CMAX;
      least_y_r   <= CMAX;
      most_x_r    <= CMIN;
      most_y_r    <= CMIN;
      seen_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      least_x_r   <= least_x_nxt;
      least_y_r   <= least_y_nxt;
      most_x_r    <= most_x_nxt;
      most_y_r    <= most_y_nxt;
      seen_r      <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    far_x_r <= far_x_nxt;
    far_y_r <= far_y_nxt;
    pad_w_r <= pad_w_nxt;
    pad_h_r <= pad_h_nxt;
    clip_r  <= clip_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.pos_x         = pos_x_r;
  assign out_ch.pos_y         = pos_y_r;
  assign out_ch.far_x         = far_x_r;
  assign out_ch.far_y         = far_y_r;
  assign out_ch.padded_width  = pad_w_r;
  assign out_ch.padded_height = pad_h_r;
  assign out_ch.clipped       = clip_r;

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (q_ctl.op == OP_REPORT) |=> !seen_r)
    else $error("tracking not cleared after a bounding box report");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (least_x_r <= most_x_r) && (least_y_r <= most_y_r))
    else $error("bounding box minimum above maximum");

  a_empty_box_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (least_x_r == CMAX) && (most_y_r == CMIN))
    else $error("empty tracking holds stale bounds");

  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_PIXEL) |-> (pad_w_r == '0) && (far_x_r == '0))
    else $error("pixel word carries summary fields");

endmodule

FILE: rtl/core/chain_code_trace_with_bounding_box.sv
// ----------------------------------------------------------------------------
// chain_code_trace_with_bounding_box
// Freeman chain code decoder with bounding box tracking.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while the queue has room and
// returns one result word for each start, step or finish word, in order; the
// unused function code is taken and dropped. A start word loads the start
// point, clamped to the signed COORD_WIDTH range, and selects eight- or
// four-direction codes. A step word moves one unit and returns the new pixel;
// clipped marks a move or start point that hit the range limit on either
// axis. A finish word returns the bounding box of every pixel since reset or
// the last finish, with padded width and height, and then clears the
// tracking. Throughput is one word per cycle in both directions while the
// sink takes each result. The front end is combinational and writes the
// decoded word into the queue when it accepts it, and the back end takes it
// from the queue into the output register, which offers the result.
// The per-word work is a small saturating add and the four min/max compares
// in the back end, and the current point and the running box are the only
// loops there. A two word queue between the two halves, plus the output
// register, lets the input keep flowing while a result waits for the sink.
// ----------------------------------------------------------------------------
module chain_code_trace_with_bounding_box #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cctbb_in_if.sink    in_ch,
  cctbb_out_if.source out_ch
);
  import cctbb_pkg::*;

  // Queue word: control, then x, then y.
  localparam int CTL_W = $bits(cctbb_ctl_t);
  localparam int DW    = CTL_W + 2 * COORD_WIDTH;

  logic                          push;
  logic                          q_ready;
  cctbb_ctl_t                    push_ctl;
  logic signed [COORD_WIDTH-1:0] push_x;
  logic signed [COORD_WIDTH-1:0] push_y;
  logic                          pop;
  logic                          q_valid;
  logic [DW-1:0]                 q_data;
  cctbb_ctl_t                    q_ctl;
  logic signed [COORD_WIDTH-1:0] q_x;
  logic signed [COORD_WIDTH-1:0] q_y;

  // Front end: accepts words, clamps start points, decodes directions.
  cctbb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_ready  (q_ready),
    .push     (push),
    .push_ctl (push_ctl),
    .push_x   (push_x),
    .push_y   (push_y)
  );

  cctbb_queue #(
    .DW(DW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_ctl, push_x, push_y}),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign q_ctl = q_data[DW-1 -: CTL_W];
  assign q_x   = q_data[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign q_y   = q_data[COORD_WIDTH-1:0];

  // Back end: current point, bounding box and the output register.
  cctbb_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ctl   (q_ctl),
    .q_x     (q_x),
    .q_y     (q_y),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
